FILE: src/ukht_pkg.sv
package ukht_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam int MIN_BUCKETS = 13;
  localparam int CFG_W       = 7;
  localparam int HALF_W      = 64;
  localparam int CNT_W       = 9;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction, start remainder
    logic div_step;   // one restoring-division bit
    logic slot_rd;    // issue slot memory read
    logic slot_eval;  // compare read data with key
    logic commit;     // apply the operation, build result
    logic wipe;       // clear valid bits and count
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic slot_last;
  } dp_stat_t;

endpackage

FILE: src/ukht_datapath.sv
module ukht_datapath import ukht_pkg::*; #(
  parameter int MAX_BUCKETS      = 64,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          opcode,
  input  logic [HALF_W-1:0]   key_high,
  input  logic [HALF_W-1:0]   key_low,
  input  logic [HALF_W-1:0]   value_in,
  output logic                found,
  output logic [HALF_W-1:0]   old_value,
  output logic [CNT_W-1:0]    entry_count,
  output logic                status
);

  localparam int TOTAL    = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int BKT_W    = $clog2(MAX_BUCKETS + 1);
  localparam int SLOT_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ADDR_W   = $clog2(TOTAL);
  localparam int ECNT_W   = $clog2(TOTAL + 1);
  localparam int REM_W    = BKT_W + 1;

  logic [CFG_W-1:0] bkt_setting;
  logic [BKT_W-1:0] modulus;

  logic [1:0]        op;
  logic [HALF_W-1:0] kh, kl, val;
  logic [HALF_W-1:0] dividend;
  logic [REM_W-1:0]  rem;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W:0]   slot_cnt;

  logic [HALF_W-1:0] mem_kh [TOTAL];
  logic [HALF_W-1:0] mem_kl [TOTAL];
  logic [HALF_W-1:0] mem_val [TOTAL];
  logic [HALF_W-1:0] rd_kh, rd_kl, rd_val;
  logic [TOTAL-1:0]  valid;
  logic [ECNT_W-1:0] count;

  logic              hit, has_free;
  logic [ADDR_W-1:0] hit_addr, free_addr;
  logic [HALF_W-1:0] hit_val;
  logic [ADDR_W-1:0] rd_addr, rd_addr_q;

  logic [REM_W-1:0]  rem_shift;
  logic [ADDR_W-1:0] base;

  // effective modulus, clamped to [13, MAX_BUCKETS]
  always_comb begin
    if (int'(bkt_setting) < MIN_BUCKETS) begin
      modulus = BKT_W'(MIN_BUCKETS);
    end else if (int'(bkt_setting) > MAX_BUCKETS) begin
      modulus = BKT_W'(MAX_BUCKETS);
    end else begin
      modulus = BKT_W'(bkt_setting);
    end
  end

  assign rem_shift = {rem[REM_W-2:0], dividend[HALF_W-1]};
  assign base      = ADDR_W'(rem) * ADDR_W'(SLOTS_PER_BUCKET);
  assign rd_addr   = base + ADDR_W'(slot);

  assign stat.is_clear  = (op == OP_CLEAR);
  assign stat.slot_last = (slot_cnt == (SLOT_W+1)'(SLOTS_PER_BUCKET - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      bkt_setting <= CFG_W'(MIN_BUCKETS);
    end else if (cfg_we) begin
      bkt_setting <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_rd) begin
      rd_kh  <= mem_kh[rd_addr];
      rd_kl  <= mem_kl[rd_addr];
      rd_val <= mem_val[rd_addr];
    end
    if (cmd.commit && op == OP_INSERT) begin
      if (hit) begin
        mem_val[hit_addr] <= val;
      end else if (has_free) begin
        mem_kh[free_addr]  <= kh;
        mem_kl[free_addr]  <= kl;
        mem_val[free_addr] <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= opcode;
      kh       <= key_high;
      kl       <= key_low;
      val      <= value_in;
      dividend <= key_high ^ key_low;
    end
    if (cmd.div_step) begin
      dividend <= {dividend[HALF_W-2:0], 1'b0};
      if (rem_shift >= REM_W'(modulus)) begin
        rem <= rem_shift - REM_W'(modulus);
      end else begin
        rem <= rem_shift;
      end
    end else if (cmd.load) begin
      rem <= '0;
    end
    if (cmd.load) begin
      slot     <= '0;
      slot_cnt <= '0;
      hit      <= 1'b0;
      has_free <= 1'b0;
    end else if (cmd.slot_rd) begin
      rd_addr_q <= rd_addr;
      if (SLOTS_PER_BUCKET > 1) begin
        slot <= slot + 1'b1;
      end
    end
    if (cmd.slot_eval) begin
      slot_cnt <= slot_cnt + 1'b1;
      if (valid[rd_addr_q]) begin
        if (!hit && rd_kh == kh && rd_kl == kl) begin
          hit      <= 1'b1;
          hit_addr <= rd_addr_q;
          hit_val  <= rd_val;
        end
      end else if (!has_free) begin
        has_free  <= 1'b1;
        free_addr <= rd_addr_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cfg_we || cmd.wipe) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      if (op == OP_INSERT && !hit && has_free) begin
        valid[free_addr] <= 1'b1;
        count <= count + 1'b1;
      end else if (op == OP_ERASE && hit) begin
        valid[hit_addr] <= 1'b0;
        count <= count - 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.wipe) begin
      found       <= 1'b0;
      old_value   <= '0;
      status      <= 1'b0;
      entry_count <= '0;
    end else if (cmd.commit) begin
      found     <= hit;
      old_value <= hit ? hit_val : '0;
      status    <= (op == OP_INSERT) && !hit && !has_free;
      if (op == OP_INSERT && !hit && has_free) begin
        entry_count <= CNT_W'(count + 1'b1);
      end else if (op == OP_ERASE && hit) begin
        entry_count <= CNT_W'(count - 1'b1);
      end else begin
        entry_count <= CNT_W'(count);
      end
    end
  end

endmodule

FILE: src/ukht_ctrl.sv
module ukht_ctrl import ukht_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_EVAL, S_COMMIT, S_OUT
  } state_t;

  state_t     state;
  logic [5:0] bit_cnt;
  logic       take;

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    cmd.load      = take;
    cmd.div_step  = (state == S_DIV);
    cmd.slot_rd   = (state == S_RD);
    cmd.slot_eval = (state == S_EVAL);
    cmd.commit    = (state == S_COMMIT) && !stat.is_clear;
    cmd.wipe      = (state == S_COMMIT) && stat.is_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bit_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state   <= S_DIV;
            bit_cnt <= '0;
          end
        end
        S_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (stat.is_clear) begin
            state <= S_COMMIT;
          end else if (bit_cnt == 6'd63) begin
            state <= S_RD;
          end
        end
        S_RD:   state <= S_EVAL;
        S_EVAL: state <= stat.slot_last ? S_COMMIT : S_RD;
        S_COMMIT: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            state     <= S_IDLE;
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/uuid_keyed_hash_table.sv
// Hash table keyed by a 128-bit id (key_high, key_low) holding 64-bit values.
// Input channel: in_valid / in_stall carry opcode, key halves and value_in;
// a transaction is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall carry found, old_value, entry_count
// and status; one result per input transaction, held while out_stall is high.
// Operations: lookup, insert (overwrite or add), erase, clear all.
// Bucket = (key_high ^ key_low) mod bucket setting, clamped to 13..MAX_BUCKETS,
// computed by a restoring divider at one quotient bit per cycle.
// Timing: one transaction at a time. Lookup/insert/erase run the divide
// steps, then a read and a compare for each bucket slot, then commit, before
// out_valid rises. Clear goes from the divide state straight to commit.
// A new transaction is taken only after the previous result has been taken.
// in_stall is high from acceptance until the result is taken.
// Config: cfg_we writes the bucket setting and empties the table; write only idle.
// Reset (rst, synchronous): bucket setting 13, table empty, no result pending.
module uuid_keyed_hash_table import ukht_pkg::*; #(
  parameter int MAX_BUCKETS      = 64,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [HALF_W-1:0] key_high,
  input  logic [HALF_W-1:0] key_low,
  input  logic [HALF_W-1:0] value_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              found,
  output logic [HALF_W-1:0] old_value,
  output logic [CNT_W-1:0]  entry_count,
  output logic              status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: divide, per-slot read/compare, commit, hold result
  ukht_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat)
  );

  // slot memories, valid bits, divider and result registers
  ukht_datapath #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .opcode(opcode), .key_high(key_high), .key_low(key_low), .value_in(value_in),
    .found(found), .old_value(old_value), .entry_count(entry_count), .status(status)
  );

endmodule
